// File: hdl/swm_pkg.sv
`default_nettype none

package swm_pkg;

  // Deepest window the candidate store can hold.
  localparam int unsigned WinMax    = 64;
  localparam int unsigned AddrW     = $clog2(WinMax);
  localparam int unsigned CntW      = AddrW + 1;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned PosW      = 8;
  localparam int unsigned FillW     = 7;
  localparam int unsigned WinCfgW   = 7;
  localparam int unsigned EntryW    = PosW + SampleW;
  localparam int unsigned DiffW     = SampleW + 1;

  localparam logic [FillW-1:0]   FillLimit  = FillW'(127);
  localparam logic [WinCfgW-1:0] WinReset   = WinCfgW'(3);
  localparam logic [CntW-1:0]    CntFull    = CntW'(WinMax);

  // Operations of the shared compare unit.
  typedef enum logic [0:0] {
    OP_AGE  = 1'b0,  // candidate age has reached the window length
    OP_LESS = 1'b1   // candidate value is strictly below the new sample
  } swm_op_e;

  typedef struct packed {
    swm_op_e                    op;
    logic signed [SampleW-1:0]  cand_val;
    logic signed [SampleW-1:0]  sample;
    logic [PosW-1:0]            pos_now;
    logic [PosW-1:0]            pos_cand;
    logic [CntW-1:0]            win;
  } cmp_req_t;

  // Clamp the programmed window into 1 .. WinMax.
  function automatic logic [CntW-1:0] eff_window(input logic [WinCfgW-1:0] w);
    logic [CntW-1:0] k;
    k = CntW'(w);
    if (w == '0) begin
      k = CntW'(1);
    end else if (CntW'(w) > CntFull) begin
      k = CntFull;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: hdl/swm_cmp.sv
`default_nettype none

module swm_cmp
  import swm_pkg::*;
(
  input  cmp_req_t req_i,
  output logic     hit_o
);

  logic [DiffW-1:0] opa;
  logic [DiffW-1:0] opb;
  logic [DiffW-1:0] diff;

  // One subtractor serves both questions. For the age check the positions
  // are zero extended and the low bits give the age modulo the position
  // range; for the value check the sign bit of the difference gives less-than.
  always_comb begin
    unique case (req_i.op)
      OP_AGE: begin
        opa = DiffW'(req_i.pos_now);
        opb = DiffW'(req_i.pos_cand);
      end
      OP_LESS: begin
        opa = {req_i.cand_val[SampleW-1], req_i.cand_val};
        opb = {req_i.sample[SampleW-1], req_i.sample};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign diff = opa - opb;

  always_comb begin
    unique case (req_i.op)
      OP_AGE:  hit_o = (diff[PosW-1:0] >= PosW'(req_i.win));
      OP_LESS: hit_o = diff[DiffW-1];
      default: hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/sliding_window_maximum_core.sv
`default_nettype none

// Running maximum over the last window_size signed samples of a stream.
// Candidates are kept as a monotonic deque in a 64-entry circular memory
// (value and 8-bit position per entry); a small sequencer walks it with one
// shared subtract-and-compare unit. An item with tuser set starts a new
// sequence and empties the deque first. Per item the block accepts it, then
// reads and drops every candidate that has expired from the front and every
// smaller candidate from the back, each walk ending on a check that keeps the
// candidate or on an empty deque, appends the sample and, when a result is
// due, reads the front and hands it to the output register, waiting there
// while an earlier result has not been taken. Input tready is high only while
// the sequencer is idle, so a new item is taken only once the last is through.
// A result appears once window_size samples of the sequence have arrived;
// the output register lets the next item be taken while a result still
// waits. window_size 0 acts as 1 and values above 64 act as 64.
// Configuration may be written only while no item is in flight.
module sliding_window_maximum_core
  import swm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SampleW-1:0]   s_axis_tdata,   // [31:0] sample
  input  logic                 s_axis_tuser,   // [0] first

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SampleW-1:0]   m_axis_tdata,   // [31:0] window_max

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [WinCfgW-1:0]   cfg_data_i      // window_size
);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXP_RD   = 8'b0000_0010,
    S_EXP_CHK  = 8'b0000_0100,
    S_BCK_RD   = 8'b0000_1000,
    S_BCK_CHK  = 8'b0001_0000,
    S_APPEND   = 8'b0010_0000,
    S_FRONT_RD = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e                     state_q, state_d;
  logic [AddrW-1:0]           head_q, head_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic [FillW-1:0]           fill_q, fill_d;
  logic [WinCfgW-1:0]         win_q;
  logic signed [SampleW-1:0]  samp_q;
  logic [SampleW-1:0]         out_q;
  logic                       out_valid_q, out_valid_d;

  logic [EntryW-1:0]          mem_q [WinMax];
  logic [EntryW-1:0]          rd_q;
  logic                       rd_en;
  logic [AddrW-1:0]           rd_addr;
  logic                       wr_en;
  logic [AddrW-1:0]           wr_addr;

  logic [CntW-1:0]            win_k;
  logic [FillW-1:0]           fill_inc;
  logic                       in_acc;
  logic                       out_load;
  cmp_req_t                   cmp_req;
  logic                       cmp_hit;

  assign win_k         = eff_window(win_q);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign fill_inc      = (fill_q == FillLimit) ? fill_q : fill_q + FillW'(1);

  // The shared compare unit looks at whichever entry was read last cycle.
  always_comb begin
    cmp_req.op       = (state_q == S_EXP_CHK) ? OP_AGE : OP_LESS;
    cmp_req.cand_val = rd_q[SampleW-1:0];
    cmp_req.sample   = samp_q;
    cmp_req.pos_now  = pos_q;
    cmp_req.pos_cand = rd_q[EntryW-1:SampleW];
    cmp_req.win      = win_k;
  end

  swm_cmp u_cmp (
    .req_i (cmp_req),
    .hit_o (cmp_hit)
  );

  // Appending always lands at head + count: when the deque is full the front
  // is dropped, which moves head forward by one while count stays the same.
  assign wr_addr = head_q + cnt_q[AddrW-1:0];

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    fill_d   = fill_q;
    rd_en    = 1'b0;
    rd_addr  = head_q;
    wr_en    = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            cnt_d  = '0;
            fill_d = '0;
            pos_d  = '0;
          end
          state_d = S_EXP_RD;
        end
      end
      S_EXP_RD: begin
        // An empty deque has nothing to expire and nothing to drop.
        if (cnt_q == '0) begin
          state_d = S_APPEND;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (cmp_hit) begin
          head_d  = head_q + AddrW'(1);
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_EXP_RD;
        end else begin
          state_d = S_BCK_RD;
        end
      end
      S_BCK_RD: begin
        if (cnt_q == '0) begin
          state_d = S_APPEND;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q + cnt_q[AddrW-1:0] - AddrW'(1);
          state_d = S_BCK_CHK;
        end
      end
      S_BCK_CHK: begin
        if (cmp_hit) begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_BCK_RD;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        wr_en  = 1'b1;
        pos_d  = pos_q + PosW'(1);
        fill_d = fill_inc;
        if (cnt_q == CntFull) begin
          head_d = head_q + AddrW'(1);
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
        state_d = (CntW'(fill_inc) >= win_k) ? S_FRONT_RD : S_IDLE;
      end
      S_FRONT_RD: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        // Wait here only while an earlier result is still unclaimed.
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      win_q       <= WinReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q <= s_axis_tdata;
    end
    if (out_load) begin
      out_q <= rd_q[SampleW-1:0];
    end
  end

  // Candidate memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= {pos_q, samp_q};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // The deque never holds more entries than the memory has.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("candidate count exceeds memory depth");

  // After an append the deque holds at least the new sample.
  a_append_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPEND) |=> (cnt_q != '0))
    else $error("deque empty right after append");

  // A new result only appears after the front entry was read out.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)) |->
      $past(state_q == S_DONE))
    else $error("result raised outside of the result state");

endmodule

`default_nettype wire
